/* hw/rtl/bms_pkg.sv */
// Package for the buzzer melody sequencer: input codes, status record,
// melody note table and melody length table. No dependencies.
`default_nettype none

package bms_pkg;

  localparam int NUM_SOUNDS = 6;
  localparam int MAX_NOTES  = 8;
  localparam int ROM_SOUNDS = 6;
  localparam int ROM_NOTES  = 7;

  localparam int TONE_W = 12;
  localparam int MS_W   = 9;
  localparam int IDX_W  = 4;
  localparam int SND_W  = 3;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_PLAY = 2'd1,
    MODE_STOP = 2'd2
  } bms_mode_t;

  typedef struct packed {
    logic [TONE_W-1:0] freq;
    logic [MS_W-1:0]   ms;
  } bms_note_t;

  typedef struct packed {
    logic [TONE_W-1:0] tone;
    logic              armed;
  } bms_status_t;

  function automatic logic [IDX_W-1:0] length_rom(input logic [SND_W-1:0] id);
    logic [IDX_W-1:0] len;
    case (id)
      3'd0:    len = 4'd7;
      3'd1:    len = 4'd3;
      3'd2:    len = 4'd3;
      3'd3:    len = 4'd3;
      3'd4:    len = 4'd2;
      3'd5:    len = 4'd2;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [IDX_W-1:0] melody_length(input logic [SND_W-1:0] id);
    logic [IDX_W-1:0] len;
    len = length_rom(id);
    if (int'(id) >= ROM_SOUNDS || int'(id) >= NUM_SOUNDS) begin
      len = '0;
    end else if (int'(len) > MAX_NOTES) begin
      len = IDX_W'(MAX_NOTES);
    end
    return len;
  endfunction

  function automatic bms_note_t note_rom(input logic [SND_W-1:0] id,
                                         input logic [2:0] idx);
    bms_note_t n;
    case ({id, idx})
      6'o00:   n = '{12'd1047, 9'd90};
      6'o01:   n = '{12'd0,    9'd30};
      6'o02:   n = '{12'd1319, 9'd90};
      6'o03:   n = '{12'd0,    9'd30};
      6'o04:   n = '{12'd1568, 9'd120};
      6'o05:   n = '{12'd0,    9'd30};
      6'o06:   n = '{12'd2093, 9'd320};
      6'o10:   n = '{12'd1319, 9'd50};
      6'o11:   n = '{12'd1568, 9'd50};
      6'o12:   n = '{12'd2093, 9'd90};
      6'o20:   n = '{12'd440,  9'd200};
      6'o21:   n = '{12'd0,    9'd60};
      6'o22:   n = '{12'd349,  9'd260};
      6'o30:   n = '{12'd988,  9'd110};
      6'o31:   n = '{12'd0,    9'd70};
      6'o32:   n = '{12'd988,  9'd110};
      6'o40:   n = '{12'd1047, 9'd60};
      6'o41:   n = '{12'd1568, 9'd90};
      6'o50:   n = '{12'd1568, 9'd60};
      6'o51:   n = '{12'd1047, 9'd90};
      default: n = '{12'd0,    9'd0};
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/bms_seq.sv */
// Melody sequencer state: timer, note pointer, armed flag and driven tone.
// Depends on bms_pkg for the note and length tables.
`default_nettype none

module bms_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [1:0]                mode,
  input  logic [bms_pkg::SND_W-1:0] sound_id,
  output bms_pkg::bms_status_t      status_next
);
  import bms_pkg::*;

  logic [SND_W-1:0]  active_sound, active_sound_next;
  logic [IDX_W-1:0]  note_index, note_index_next;
  logic [MS_W-1:0]   ticks_left, ticks_left_next;
  logic              armed, armed_next;
  logic [TONE_W-1:0] current_tone, current_tone_next;

  logic [IDX_W-1:0]  cur_len;
  logic [MS_W-1:0]   ticks_dec;
  bms_note_t         note;

  always_comb begin
    cur_len   = melody_length(active_sound);
    ticks_dec = ticks_left - MS_W'(1);
    note      = note_rom(active_sound, note_index[2:0]);

    active_sound_next = active_sound;
    note_index_next   = note_index;
    ticks_left_next   = ticks_left;
    armed_next        = armed;
    current_tone_next = current_tone;

    case (bms_mode_t'(mode))
      MODE_TICK: begin
        if (ticks_left != '0) begin
          ticks_left_next = ticks_dec;
          if (ticks_dec == '0) begin
            if (!armed || note_index >= cur_len || int'(note_index) >= ROM_NOTES) begin
              current_tone_next = '0;
              armed_next        = 1'b0;
              ticks_left_next   = '0;
            end else begin
              current_tone_next = note.freq;
              note_index_next   = note_index + IDX_W'(1);
              ticks_left_next   = (note.ms != '0) ? note.ms : MS_W'(1);
            end
          end
        end
      end
      MODE_PLAY: begin
        if (melody_length(sound_id) != '0) begin
          active_sound_next = sound_id;
          note_index_next   = '0;
          armed_next        = 1'b1;
          ticks_left_next   = MS_W'(1);
        end
      end
      MODE_STOP: begin
        active_sound_next = '0;
        note_index_next   = '0;
        ticks_left_next   = '0;
        armed_next        = 1'b0;
        current_tone_next = '0;
      end
      default: begin
      end
    endcase

    status_next.tone  = current_tone_next;
    status_next.armed = armed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_sound <= '0;
      note_index   <= '0;
      ticks_left   <= '0;
      armed        <= 1'b0;
      current_tone <= '0;
    end else if (step) begin
      active_sound <= active_sound_next;
      note_index   <= note_index_next;
      ticks_left   <= ticks_left_next;
      armed        <= armed_next;
      current_tone <= current_tone_next;
    end
  end

`ifndef SYNTHESIS
  a_idle_timer_stopped: assert property (@(posedge clk) disable iff (rst)
    !armed |-> ticks_left == '0)
    else $error("timer running while idle");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    step && mode == MODE_STOP |=> !armed && current_tone == '0 && ticks_left == '0)
    else $error("stop did not clear state");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    armed |-> int'(note_index) <= ROM_NOTES)
    else $error("note index beyond melody");

  a_play_arms: assert property (@(posedge clk) disable iff (rst)
    step && mode == MODE_PLAY && melody_length(sound_id) != '0
      |=> armed && ticks_left == MS_W'(1) && note_index == '0)
    else $error("play did not arm sequencer");
`endif

endmodule

`default_nettype wire

/* hw/rtl/buzzer_melody_sequencer.sv */
// Top level of the buzzer melody sequencer: input register, sequencer
// state and result register. Depends on bms_pkg and bms_seq.
`default_nettype none

// One transfer in gives one transfer out. A new input is taken every cycle
// while the result side keeps up. The input register captures an item at its
// input transfer, and the sequencer update computed from it is loaded into the
// result register when the item advances, which a stalled result delays. A
// stalled result holds both registers.

module buzzer_melody_sequencer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 mode,
  input  logic [bms_pkg::SND_W-1:0]  sound_id,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bms_pkg::TONE_W-1:0] tone_hz,
  output logic                       sounding,
  output logic                       playing
);
  import bms_pkg::*;

  logic             s1_valid;
  logic [1:0]       s1_mode;
  logic [SND_W-1:0] s1_sound;
  logic             advance;
  logic             accept;
  bms_status_t      status_next;

  assign advance  = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode  <= mode;
      s1_sound <= sound_id;
    end
  end

  bms_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .mode        (s1_mode),
    .sound_id    (s1_sound),
    .status_next (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tone_hz  <= status_next.tone;
      sounding <= (status_next.tone != '0);
      playing  <= status_next.armed;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with room to spare");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced item produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tone_hz) && $stable(playing))
    else $error("held result overwritten");
`endif

endmodule

`default_nettype wire

/* test/bms_checker.sv */
// Checker for the buzzer melody sequencer: watches both channels, keeps its own
// copy of the sequencer state and compares every result transfer with the status
// it predicts. Depends on bms_pkg for the mode codes and limits.

module bms_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [1:0]                 mode,
  input  logic [bms_pkg::SND_W-1:0]  sound_id,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [bms_pkg::TONE_W-1:0] tone_hz,
  input  logic                       sounding,
  input  logic                       playing,
  output int                         fail_count,
  output int                         pending
);

  localparam int TUNES      = 6;
  localparam int TUNE_NOTES = 7;

  localparam logic [11:0] TONE_TAB [0:41] = '{
    12'd1047, 12'd0,    12'd1319, 12'd0,    12'd1568, 12'd0,    12'd2093,
    12'd1319, 12'd1568, 12'd2093, 12'd0,    12'd0,    12'd0,    12'd0,
    12'd440,  12'd0,    12'd349,  12'd0,    12'd0,    12'd0,    12'd0,
    12'd988,  12'd0,    12'd988,  12'd0,    12'd0,    12'd0,    12'd0,
    12'd1047, 12'd1568, 12'd0,    12'd0,    12'd0,    12'd0,    12'd0,
    12'd1568, 12'd1047, 12'd0,    12'd0,    12'd0,    12'd0,    12'd0
  };

  localparam logic [15:0] MS_TAB [0:41] = '{
    16'd90,  16'd30, 16'd90,  16'd30, 16'd120, 16'd30, 16'd320,
    16'd50,  16'd50, 16'd90,  16'd0,  16'd0,   16'd0,  16'd0,
    16'd200, 16'd60, 16'd260, 16'd0,  16'd0,   16'd0,  16'd0,
    16'd110, 16'd70, 16'd110, 16'd0,  16'd0,   16'd0,  16'd0,
    16'd60,  16'd90, 16'd0,   16'd0,  16'd0,   16'd0,  16'd0,
    16'd60,  16'd90, 16'd0,   16'd0,  16'd0,   16'd0,  16'd0
  };

  localparam int NOTE_COUNT [0:5] = '{7, 3, 3, 3, 2, 2};

  typedef struct {
    logic [bms_pkg::TONE_W-1:0] tone;
    logic                       sounding;
    logic                       armed;
  } buzzer_status_t;

  buzzer_status_t status_due_q [$];

  logic [2:0]  cur_sound;
  logic [3:0]  cur_note;
  logic [15:0] wait_ms;
  logic        seq_armed;
  logic [11:0] drive_tone;

  function automatic int notes_in(input logic [2:0] id);
    int len;
    if (int'(id) >= TUNES || int'(id) >= bms_pkg::NUM_SOUNDS) begin
      return 0;
    end
    len = NOTE_COUNT[id];
    if (len > bms_pkg::MAX_NOTES) begin
      len = bms_pkg::MAX_NOTES;
    end
    return len;
  endfunction

  task automatic load_next_note();
    int          len;
    int          slot;
    logic [15:0] ms;
    len = notes_in(cur_sound);
    if (!seq_armed || int'(cur_note) >= len || int'(cur_note) >= TUNE_NOTES) begin
      drive_tone = '0;
      seq_armed  = 1'b0;
      wait_ms    = '0;
    end else begin
      slot       = int'(cur_sound) * TUNE_NOTES + int'(cur_note);
      drive_tone = TONE_TAB[slot];
      ms         = MS_TAB[slot];
      cur_note   = cur_note + 4'd1;
      wait_ms    = (ms != 16'd0) ? ms : 16'd1;
    end
  endtask

  task automatic play_step(input logic [1:0] m, input logic [2:0] id);
    buzzer_status_t st;
    case (m)
      bms_pkg::MODE_TICK: begin
        if (wait_ms != 16'd0) begin
          wait_ms = wait_ms - 16'd1;
          if (wait_ms == 16'd0) begin
            load_next_note();
          end
        end
      end
      bms_pkg::MODE_PLAY: begin
        if (notes_in(id) != 0) begin
          cur_sound = id;
          cur_note  = '0;
          seq_armed = 1'b1;
          wait_ms   = 16'd1;
        end
      end
      bms_pkg::MODE_STOP: begin
        cur_sound  = '0;
        cur_note   = '0;
        wait_ms    = '0;
        seq_armed  = 1'b0;
        drive_tone = '0;
      end
      default: begin
      end
    endcase
    st.tone     = drive_tone;
    st.sounding = (drive_tone != '0);
    st.armed    = seq_armed;
    status_due_q.push_back(st);
  endtask

  task automatic flag_mismatch(input string what);
    if (fail_count < 10) begin
      $display("%0t mismatch: %s", $realtime, what);
    end
    fail_count = fail_count + 1;
  endtask

  always @(posedge clk) begin
    buzzer_status_t due;
    if (rst) begin
      cur_sound  = '0;
      cur_note   = '0;
      wait_ms    = '0;
      seq_armed  = 1'b0;
      drive_tone = '0;
      status_due_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status_due_q.size() == 0) begin
          flag_mismatch($sformatf("result tone %0d sounding %0b playing %0b with none due",
                                  tone_hz, sounding, playing));
        end else begin
          due = status_due_q.pop_front();
          if (tone_hz !== due.tone || sounding !== due.sounding || playing !== due.armed) begin
            flag_mismatch($sformatf("expected tone %0d sounding %0b playing %0b, got %0d %0b %0b",
                                    due.tone, due.sounding, due.armed,
                                    tone_hz, sounding, playing));
          end
        end
      end
      if (in_valid && !in_stall) begin
        play_step(mode, sound_id);
      end
    end
    pending <= status_due_q.size();
  end

endmodule

/* test/tb_buzzer_melody_sequencer.sv */
// Testbench top for the buzzer melody sequencer: clock, reset, directed and
// random command stimulus under varying idle and stall, and the verdict.
// Depends on bms_pkg, buzzer_melody_sequencer and bms_checker.

module tb_buzzer_melody_sequencer;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int MELODY_TICKS [0:5] = '{711, 191, 521, 291, 151, 151};
  localparam int ITEM_BUDGET = 1200;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 mode = '0;
  logic [bms_pkg::SND_W-1:0]  sound_id = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [bms_pkg::TONE_W-1:0] tone_hz;
  logic                       sounding;
  logic                       playing;
  int                         fail_count;
  int                         pending;

  int in_idle_pct  = 0;
  int out_stall_pct = 0;
  int sent_items   = 0;

  buzzer_melody_sequencer DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .sound_id(sound_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .tone_hz(tone_hz), .sounding(sounding), .playing(playing)
  );

  bms_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .sound_id(sound_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .tone_hz(tone_hz), .sounding(sounding), .playing(playing),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  task automatic set_pressure(input int phase);
    case (phase)
      0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1: begin in_idle_pct = 58; out_stall_pct = 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct = 58; end
      default: begin in_idle_pct = 14; out_stall_pct = 14; end
    endcase
  endtask

  task automatic send_cmd(input logic [1:0] m, input logic [2:0] id);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    sound_id <= id;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    sent_items = sent_items + 1;
  endtask

  initial begin
    int         id;
    int         ticks;
    int         full_run;
    int         k;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_pressure(0);
    send_cmd(bms_pkg::MODE_TICK, 3'd7);
    send_cmd(MODE_UNUSED, 3'd0);
    send_cmd(bms_pkg::MODE_PLAY, 3'd6);
    send_cmd(bms_pkg::MODE_PLAY, 3'd7);
    send_cmd(bms_pkg::MODE_PLAY, 3'd0);
    send_cmd(bms_pkg::MODE_TICK, 3'd0);
    send_cmd(bms_pkg::MODE_PLAY, 3'd5);
    send_cmd(bms_pkg::MODE_PLAY, 3'd7);
    send_cmd(bms_pkg::MODE_TICK, 3'd2);
    send_cmd(MODE_UNUSED, 3'd7);
    send_cmd(bms_pkg::MODE_STOP, 3'd7);
    send_cmd(bms_pkg::MODE_TICK, 3'd5);
    set_pressure(3);
    send_cmd(bms_pkg::MODE_PLAY, 3'd2);
    send_cmd(bms_pkg::MODE_TICK, 3'd1);
    send_cmd(bms_pkg::MODE_TICK, 3'd6);
    send_cmd(bms_pkg::MODE_STOP, 3'd0);
    send_cmd(bms_pkg::MODE_PLAY, 3'd1);
    send_cmd(bms_pkg::MODE_TICK, 3'd4);
    send_cmd(bms_pkg::MODE_PLAY, 3'd3);
    send_cmd(bms_pkg::MODE_TICK, 3'd3);
    send_cmd(bms_pkg::MODE_STOP, 3'd2);

    while (sent_items < ITEM_BUDGET) begin
      set_pressure($urandom_range(3));
      if ($urandom_range(9) < 7) begin
        id = $urandom_range(5);
        send_cmd(bms_pkg::MODE_PLAY, id[2:0]);
        full_run = $urandom_range(1);
        if (full_run != 0) begin
          ticks = MELODY_TICKS[id] + $urandom_range(4);
        end else begin
          ticks = $urandom_range(MELODY_TICKS[id] - 1, 1);
        end
        if (ticks > ITEM_BUDGET - sent_items) begin
          ticks    = ITEM_BUDGET - sent_items;
          full_run = 0;
        end
        repeat (ticks) send_cmd(bms_pkg::MODE_TICK, 3'($urandom_range(7)));
        if (full_run == 0) begin
          case ($urandom_range(2))
            0: send_cmd(bms_pkg::MODE_STOP, 3'($urandom_range(7)));
            1: send_cmd(MODE_UNUSED, 3'($urandom_range(7)));
            default: begin
            end
          endcase
        end
      end else begin
        k = $urandom_range(8, 1);
        repeat (k) send_cmd(2'($urandom_range(3)), 3'($urandom_range(7)));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
